// File: hdl/irfe_pkg.sv
// Shared types, protocol codes and per-protocol timing tables of the IR frame encoder.
package irfe_pkg;

  localparam int TIME_W    = 16;
  localparam int PAYLOAD_W = 48;

  localparam logic [3:0] KIND_NEC        = 4'd0;
  localparam logic [3:0] KIND_NEC_EXT    = 4'd1;
  localparam logic [3:0] KIND_NEC42      = 4'd2;
  localparam logic [3:0] KIND_NEC42_EXT  = 4'd3;
  localparam logic [3:0] KIND_SAMSUNG32  = 4'd4;
  localparam logic [3:0] KIND_SIRC12     = 4'd5;
  localparam logic [3:0] KIND_SIRC15     = 4'd6;
  localparam logic [3:0] KIND_SIRC20     = 4'd7;
  localparam logic [3:0] KIND_RCA        = 4'd8;
  localparam logic [3:0] KIND_RC5        = 4'd9;
  localparam logic [3:0] KIND_RC5X       = 4'd10;
  localparam logic [3:0] KIND_RC6        = 4'd11;
  localparam logic [3:0] KIND_KASEIKYO   = 4'd12;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] address;
    logic [15:0] command;
  } req_t;

  typedef struct packed {
    logic [15:0] mark_us;
    logic [15:0] space_us;
    logic        last;
    logic        unsupported;
  } res_t;

  // One mark (level 1) or space (level 0) entry.
  typedef struct packed {
    logic              level;
    logic [TIME_W-1:0] dur;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic error;
    logic step;
    logic second_valid;
    logic flush;
  } merge_ctl_t;

  // Timing of one protocol; bit_m is the half-bit time for Manchester frames.
  typedef struct packed {
    logic              supported;
    logic              manch;
    logic              has_lead;
    logic [5:0]        bits;
    logic [TIME_W-1:0] lead_m;
    logic [TIME_W-1:0] lead_s;
    logic [TIME_W-1:0] bit_m;
    logic [TIME_W-1:0] zero_s;
    logic [TIME_W-1:0] one_s;
    logic [TIME_W-1:0] stop_m;
  } timing_t;

  function automatic timing_t get_timing(logic [3:0] kind);
    timing_t t;
    t = '0;
    t.supported = 1'b1;
    t.has_lead  = 1'b1;
    case (kind) inside
      [KIND_NEC:KIND_NEC42_EXT]: begin
        t.bits = 6'd32; t.lead_m = 16'd9000; t.lead_s = 16'd4500;
        t.bit_m = 16'd560; t.zero_s = 16'd560; t.one_s = 16'd1690; t.stop_m = 16'd560;
      end
      KIND_SAMSUNG32: begin
        t.bits = 6'd32; t.lead_m = 16'd4500; t.lead_s = 16'd4500;
        t.bit_m = 16'd560; t.zero_s = 16'd560; t.one_s = 16'd1690; t.stop_m = 16'd560;
      end
      [KIND_SIRC12:KIND_SIRC20]: begin
        t.bits = (kind == KIND_SIRC12) ? 6'd12 : ((kind == KIND_SIRC15) ? 6'd15 : 6'd20);
        t.lead_m = 16'd2400; t.lead_s = 16'd600;
        t.bit_m = 16'd600; t.zero_s = 16'd600; t.one_s = 16'd1200; t.stop_m = 16'd600;
      end
      KIND_RCA: begin
        t.bits = 6'd12; t.lead_m = 16'd4000; t.lead_s = 16'd4000;
        t.bit_m = 16'd500; t.zero_s = 16'd1000; t.one_s = 16'd2000; t.stop_m = 16'd500;
      end
      KIND_RC5, KIND_RC5X: begin
        t.manch = 1'b1; t.has_lead = 1'b0;
        t.bits = (kind == KIND_RC5) ? 6'd14 : 6'd15;
        t.bit_m = 16'd889;
      end
      KIND_RC6: begin
        t.manch = 1'b1;
        t.bits = 6'd20; t.lead_m = 16'd2666; t.lead_s = 16'd889;
        t.bit_m = 16'd444;
      end
      KIND_KASEIKYO: begin
        t.bits = 6'd48; t.lead_m = 16'd3456; t.lead_s = 16'd1728;
        t.bit_m = 16'd432; t.zero_s = 16'd432; t.one_s = 16'd1296; t.stop_m = 16'd432;
      end
      default: begin
        t.supported = 1'b0;
      end
    endcase
    return t;
  endfunction

  // Payload word: LSB-first protocols sit at bit 0, Manchester ones are MSB aligned.
  function automatic logic [PAYLOAD_W-1:0] build_payload(req_t r);
    logic [7:0]            a8;
    logic [7:0]            c8;
    logic [13:0]           rc5;
    logic [PAYLOAD_W-1:0]  p;
    a8  = r.address[7:0];
    c8  = r.command[7:0];
    rc5 = {2'b11, 1'b0, r.address[4:0], r.command[5:0]};
    case (r.kind) inside
      KIND_NEC:                           p = {16'd0, ~c8, c8, ~a8, a8};
      [KIND_NEC_EXT:KIND_SAMSUNG32]:      p = {16'd0, ~c8, c8, r.address[15:0]};
      [KIND_SIRC12:KIND_SIRC20]:          p = {9'd0, r.address, r.command[6:0]};
      KIND_RCA:                           p = {36'd0, r.address[3:0], c8};
      KIND_RC5:                           p = {rc5, 34'd0};
      KIND_RC5X:                          p = {1'b0, rc5, 33'd0};
      KIND_RC6:                           p = {4'd0, a8, c8, 28'd0};
      KIND_KASEIKYO:                      p = {r.address, r.command};
      default:                            p = '0;
    endcase
    return p;
  endfunction

endpackage

// File: hdl/irfe_merge.sv
// Entry merger: joins same-level entries and emits mark/space pairs at most one per cycle.
module irfe_merge #(
  parameter int DURATION_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  irfe_pkg::merge_ctl_t ctl,
  input  irfe_pkg::entry_t    first,
  input  irfe_pkg::entry_t    second,
  output logic                strobe,
  output irfe_pkg::res_t      result
);
  import irfe_pkg::*;

  typedef struct packed {
    logic                      started;
    logic                      level;
    logic [DURATION_WIDTH-1:0] cur;
    logic [DURATION_WIDTH-1:0] mark;
    logic                      emit;
    logic [DURATION_WIDTH-1:0] em;
    logic [DURATION_WIDTH-1:0] es;
  } mstate_t;

  logic                      started;
  logic                      level;
  logic [DURATION_WIDTH-1:0] cur_dur;
  logic [DURATION_WIDTH-1:0] mark_dur;
  mstate_t                   s0, s1, s2;
  logic                      emit_next;
  logic [DURATION_WIDTH-1:0] em_next;
  logic [DURATION_WIDTH-1:0] es_next;

  function automatic logic [DURATION_WIDTH-1:0] sat_add(logic [DURATION_WIDTH-1:0] a,
                                                        logic [DURATION_WIDTH-1:0] b);
    logic [DURATION_WIDTH:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DURATION_WIDTH] ? {DURATION_WIDTH{1'b1}} : sum[DURATION_WIDTH-1:0];
  endfunction

  function automatic mstate_t put_entry(mstate_t s, entry_t e);
    mstate_t                   f;
    logic [DURATION_WIDTH-1:0] d;
    f      = s;
    f.emit = 1'b0;
    d      = DURATION_WIDTH'(e.dur);
    if (!s.started) begin
      // drop a leading space
      if (e.level) begin
        f.started = 1'b1;
        f.level   = 1'b1;
        f.cur     = d;
      end
    end else if (e.level == s.level) begin
      f.cur = sat_add(s.cur, d);
    end else if (e.level) begin
      f.emit  = 1'b1;
      f.em    = s.mark;
      f.es    = s.cur;
      f.level = 1'b1;
      f.cur   = d;
    end else begin
      f.mark  = s.cur;
      f.level = 1'b0;
      f.cur   = d;
    end
    return f;
  endfunction

  always_comb begin
    s0.started = started;
    s0.level   = level;
    s0.cur     = cur_dur;
    s0.mark    = mark_dur;
    s0.emit    = 1'b0;
    s0.em      = '0;
    s0.es      = '0;
    s1         = put_entry(s0, first);
    s2         = ctl.second_valid ? put_entry(s1, second) : s1;
    emit_next  = s1.emit | s2.emit;
    em_next    = s1.emit ? s1.em : s2.em;
    es_next    = s1.emit ? s1.es : s2.es;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      level   <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (ctl.clear) begin
        started <= 1'b0;
      end
      if (ctl.error) begin
        strobe <= 1'b1;
        result <= '{mark_us: 16'd0, space_us: 16'd0, last: 1'b1, unsupported: 1'b1};
      end else if (ctl.step) begin
        started  <= s2.started;
        level    <= s2.level;
        cur_dur  <= s2.cur;
        mark_dur <= s2.mark;
        if (emit_next) begin
          strobe <= 1'b1;
          result <= '{mark_us: em_next[15:0], space_us: es_next[15:0],
                      last: 1'b0, unsupported: 1'b0};
        end
      end else if (ctl.flush) begin
        strobe <= 1'b1;
        if (level) begin
          result <= '{mark_us: cur_dur[15:0], space_us: 16'd0,
                      last: 1'b1, unsupported: 1'b0};
        end else begin
          result <= '{mark_us: mark_dur[15:0], space_us: cur_dur[15:0],
                      last: 1'b1, unsupported: 1'b0};
        end
      end
    end
  end

endmodule

// File: hdl/ir_remote_frame_encoder.sv
// Top level of the IR remote frame encoder: frame sequencer and payload shift register.
//
// A frame request (protocol, address, command) is taken when start is high and busy is
// low. The block then sends the frame as mark/space microsecond pairs on result, each
// pair valid for exactly one cycle while strobe is high; the receiver cannot stall, so
// every pair must be taken in that cycle. The last pair of a frame has last set. An
// unknown protocol code gives a single result with unsupported and last set, on the
// cycle after acceptance, and busy never rises for it. The payload leaves a shift
// register one bit per cycle: a frame passes through a leader step (none for RC5 and
// RC5X), a step for each payload bit, a stop mark for pulse-distance protocols and a
// flush of the final pair. busy drops as the final pair is shown, and a new request
// may be taken in that cycle.
// Manchester halves of equal level are merged before they are paired, and a leading
// space half is dropped so each frame opens on a mark.
module ir_remote_frame_encoder #(
  parameter int MAX_FRAME_BITS = 48,
  parameter int DURATION_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  irfe_pkg::req_t  request,
  output logic            strobe,
  output irfe_pkg::res_t  result
);
  import irfe_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BITS + 1);

  typedef enum logic [2:0] {
    IDLE,
    LEAD,
    BITS,
    STOP,
    FLUSH
  } phase_t;

  phase_t               phase;
  timing_t              timing;
  logic [PAYLOAD_W-1:0] payload_shift;
  logic [CNT_W-1:0]     bit_count;
  timing_t              req_timing;
  logic                 accept;
  logic                 cur_bit;
  merge_ctl_t           ctl;
  entry_t               first;
  entry_t               second;

  assign busy       = (phase != IDLE);
  assign accept     = start && !busy;
  assign req_timing = get_timing(request.kind);
  // Manchester frames go out MSB first from the top, the rest LSB first from bit 0.
  assign cur_bit    = timing.manch ? payload_shift[PAYLOAD_W-1] : payload_shift[0];

  // Entries handed to the merger for the current phase.
  always_comb begin
    ctl    = '0;
    first  = '{level: 1'b1, dur: timing.lead_m};
    second = '{level: 1'b0, dur: timing.lead_s};
    case (phase)
      IDLE: begin
        ctl.clear = accept;
        ctl.error = accept && !req_timing.supported;
      end
      LEAD: begin
        ctl.step         = 1'b1;
        ctl.second_valid = 1'b1;
      end
      BITS: begin
        ctl.step         = 1'b1;
        ctl.second_valid = 1'b1;
        if (timing.manch) begin
          first  = '{level: ~cur_bit, dur: timing.bit_m};
          second = '{level: cur_bit, dur: timing.bit_m};
        end else begin
          first  = '{level: 1'b1, dur: timing.bit_m};
          second = '{level: 1'b0, dur: cur_bit ? timing.one_s : timing.zero_s};
        end
      end
      STOP: begin
        ctl.step = 1'b1;
        first    = '{level: 1'b1, dur: timing.stop_m};
      end
      FLUSH: begin
        ctl.flush = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= IDLE;
    end else begin
      case (phase)
        IDLE: begin
          if (accept && req_timing.supported) begin
            timing        <= req_timing;
            payload_shift <= build_payload(request);
            // clip the payload length to the frame limit
            if (int'(req_timing.bits) > MAX_FRAME_BITS) begin
              bit_count <= CNT_W'(MAX_FRAME_BITS);
            end else begin
              bit_count <= CNT_W'(req_timing.bits);
            end
            phase <= req_timing.has_lead ? LEAD : BITS;
          end
        end
        LEAD: begin
          phase <= BITS;
        end
        BITS: begin
          // advance one payload bit
          if (timing.manch) begin
            payload_shift <= payload_shift << 1;
          end else begin
            payload_shift <= payload_shift >> 1;
          end
          bit_count <= bit_count - CNT_W'(1);
          if (bit_count == CNT_W'(1)) begin
            phase <= timing.manch ? FLUSH : STOP;
          end
        end
        STOP: begin
          phase <= FLUSH;
        end
        FLUSH: begin
          phase <= IDLE;
        end
        default: begin
          phase <= IDLE;
        end
      endcase
    end
  end

  irfe_merge #(
    .DURATION_WIDTH(DURATION_WIDTH)
  ) u_merge (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .first  (first),
    .second (second),
    .strobe (strobe),
    .result (result)
  );

endmodule
